/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed during reset");

`endif

/* rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, types, state codes and modular add for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int FIELD_W = 64;
    localparam int WIDTH   = 64;
    localparam int CNT_W   = $clog2(WIDTH);

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [WIDTH-1:0]   t_data;
    // modulus with a top bit: a zero modulus stands for 2^WIDTH
    typedef logic [WIDTH:0]     t_mod;

    typedef struct packed {
        logic  start;
        t_data a;
        t_data b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_data result;
    } t_mul_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_STEP,
        ST_POW,
        ST_SHIFT,
        ST_SQR,
        ST_FINAL,
        ST_DONE
    } t_state;

    // (x + y) mod n for x, y < n
    function automatic t_data add_mod(t_data x, t_data y, t_mod n);
        t_mod s;
        t_mod d;
        s = {1'b0, x} + {1'b0, y};
        d = s - n;
        return (s >= n) ? d[WIDTH-1:0] : s[WIDTH-1:0];
    endfunction

endpackage

/* rtl/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: shift-and-add over the bits of b, LSB
// first, one bit per cycle. Requires a < modulus; b may be any value.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mexp_pkg::t_mul_req i_req,
    input  mexp_pkg::t_mod     i_mod,
    output mexp_pkg::t_mul_rsp o_rsp
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [mexp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    mexp_pkg::t_data            r_a, n_a;
    mexp_pkg::t_data            r_b, n_b;
    mexp_pkg::t_data            r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = mexp_pkg::add_mod(r_acc, r_a, i_mod);
            end
            n_a   = mexp_pkg::add_mod(r_a, r_a, i_mod);
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

/* rtl/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// mexp_ctrl
// Square-and-multiply sequencer: for a nonzero exponent, reduces the base,
// walks the exponent LSB first issuing products to the serial multiplier,
// applies the starting multiplier and holds the result in the output register.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mexp_pkg::t_data    i_base,
    input  mexp_pkg::t_data    i_exponent,
    input  mexp_pkg::t_data    i_multiplier,
    output logic               o_valid,
    input  logic               i_ready,
    output mexp_pkg::t_data    o_product,
    input  mexp_pkg::t_data    i_one,
    output mexp_pkg::t_mul_req o_req,
    input  mexp_pkg::t_mul_rsp i_rsp
);

    mexp_pkg::t_state r_state, n_state;
    logic             r_wait, n_wait;
    logic             r_out_valid, n_out_valid;
    mexp_pkg::t_data  r_e, n_e;
    mexp_pkg::t_data  r_pw, n_pw;
    mexp_pkg::t_data  r_sq, n_sq;
    mexp_pkg::t_data  r_z, n_z;
    mexp_pkg::t_data  r_res, n_res;
    mexp_pkg::t_data  r_out, n_out;
    logic             mul_state;
    logic             out_free;

    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_exponent == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_RED;
                end
            end
            mexp_pkg::ST_RED: begin
                if (i_rsp.done) n_state = mexp_pkg::ST_STEP;
            end
            mexp_pkg::ST_STEP: begin
                n_state = r_e[0] ? mexp_pkg::ST_POW : mexp_pkg::ST_SHIFT;
            end
            mexp_pkg::ST_POW: begin
                if (i_rsp.done) n_state = mexp_pkg::ST_SHIFT;
            end
            mexp_pkg::ST_SHIFT: begin
                n_state = (r_e[mexp_pkg::WIDTH-1:1] != '0) ? mexp_pkg::ST_SQR
                                                            : mexp_pkg::ST_FINAL;
            end
            mexp_pkg::ST_SQR: begin
                if (i_rsp.done) n_state = mexp_pkg::ST_STEP;
            end
            mexp_pkg::ST_FINAL: begin
                if (i_rsp.done) n_state = mexp_pkg::ST_DONE;
            end
            mexp_pkg::ST_DONE: begin
                if (out_free) n_state = mexp_pkg::ST_IDLE;
            end
            default: n_state = mexp_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_ready     = (r_state == mexp_pkg::ST_IDLE);
        mul_state   = r_state inside {mexp_pkg::ST_RED, mexp_pkg::ST_POW,
                                      mexp_pkg::ST_SQR, mexp_pkg::ST_FINAL};
        o_req.start = mul_state && !r_wait;
        o_req.a     = (r_state == mexp_pkg::ST_SQR) ? r_sq : r_pw;
        o_req.b     = (r_state == mexp_pkg::ST_FINAL) ? r_z : r_sq;

        n_wait      = r_wait;
        if (o_req.start) n_wait = 1'b1;
        if (i_rsp.done)  n_wait = 1'b0;

        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        n_e         = r_e;
        n_pw        = r_pw;
        n_sq        = r_sq;
        n_z         = r_z;
        n_res       = r_res;
        case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_e   = i_exponent;
                    n_sq  = i_base;
                    n_z   = i_multiplier;
                    n_res = i_multiplier;
                    n_pw  = i_one;
                end
            end
            mexp_pkg::ST_RED: begin
                if (i_rsp.done) n_sq = i_rsp.result;
            end
            mexp_pkg::ST_POW: begin
                if (i_rsp.done) n_pw = i_rsp.result;
            end
            mexp_pkg::ST_SHIFT: begin
                n_e = r_e >> 1;
            end
            mexp_pkg::ST_SQR: begin
                if (i_rsp.done) n_sq = i_rsp.result;
            end
            mexp_pkg::ST_FINAL: begin
                if (i_rsp.done) n_res = i_rsp.result;
            end
            mexp_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e   <= n_e;
        r_pw  <= n_pw;
        r_sq  <= n_sq;
        r_z   <= n_z;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid   = r_out_valid;
    assign o_product = r_out;

endmodule

/* rtl/modular_exp_multiply.sv */
// ----------------------------------------------------------------------------
// modular_exp_multiply
// Returns multiplier * base^exponent mod modulus (for a zero exponent, the multiplier as given), one result per input.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries base, exponent and multiplier; output
// channel o_valid/i_ready carries product. One transfer in gives one transfer
// out, in order. The user must write the modulus via i_cfg_we/i_cfg_modulus only
// while no item is in flight, unchecked by the block; a zero modulus means 2^64.
// Items are processed one at a time by a single bit-serial modular
// multiplier, which takes 64 shift-add steps per product. For a zero
// exponent the item skips the multiplier: the state goes straight to done,
// then the output register is loaded. Otherwise one item uses 1 + L + P
// products (L = exponent bit length, P = exponent ones).
// o_ready is high only while no item is in progress. A finished product sits
// in the output register while the receiver stalls; the next item is
// accepted and computed meanwhile, and waits for that register to empty.
// Synchronous reset drops any item in flight, clears o_valid and sets the
// modulus to 2.
// ----------------------------------------------------------------------------
module modular_exp_multiply (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  mexp_pkg::t_field         i_base,
    input  mexp_pkg::t_field         i_exponent,
    input  mexp_pkg::t_field         i_multiplier,
    output logic                     o_valid,
    input  logic                     i_ready,
    output mexp_pkg::t_field         o_product,
    input  logic                     i_cfg_we,
    input  mexp_pkg::t_field         i_cfg_modulus
);

    mexp_pkg::t_data    r_modulus;
    mexp_pkg::t_mod     mod_ext;
    mexp_pkg::t_data    one;
    mexp_pkg::t_data    product;
    mexp_pkg::t_mul_req mul_req;
    mexp_pkg::t_mul_rsp mul_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::t_data'(2);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_modulus[mexp_pkg::WIDTH-1:0];
        end
    end

    assign mod_ext = {r_modulus == '0, r_modulus};
    // 1 mod n: zero only for a modulus of one
    assign one     = mexp_pkg::t_data'(mod_ext != mexp_pkg::t_mod'(1));

    mexp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_base       (i_base[mexp_pkg::WIDTH-1:0]),
        .i_exponent   (i_exponent[mexp_pkg::WIDTH-1:0]),
        .i_multiplier (i_multiplier[mexp_pkg::WIDTH-1:0]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_product    (product),
        .i_one        (one),
        .o_req        (mul_req),
        .i_rsp        (mul_rsp)
    );

    mexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_mod   (mod_ext),
        .o_rsp   (mul_rsp)
    );

    assign o_product = mexp_pkg::t_field'(product);

endmodule

/* rtl/mexp_checker.sv */
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks for modular_exp_multiply, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mexp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input mexp_pkg::t_field o_product
);

    logic [1:0] r_pend;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // items accepted whose result has not yet been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_product))
    `ASSERT_CLK(a_one_at_a_time, i_clk, i_rst_n, in_xfer |=> !o_ready)
    `ASSERT_CLK(a_no_spurious, i_clk, i_rst_n, o_valid |-> r_pend != 2'd0)
    `ASSERT_CLK_NORST(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind modular_exp_multiply mexp_checker u_mexp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_product (o_product)
);
